// ===== hdl/ppc_pkg.sv =====
// Shared types, constants and helpers for the polygon plane clipper.
`default_nettype none

package ppc_pkg;

  // Polygon and buffer sizes.
  localparam int MAX_IN_VERTS = 16;
  localparam int OUT_DEPTH    = 32;
  localparam int MIN_VERTS    = 3;
  localparam int NAXES        = 3;

  localparam int AW  = $clog2(OUT_DEPTH);
  localparam int CW  = $clog2(OUT_DEPTH + 1);
  localparam int ICW = $clog2(MAX_IN_VERTS + 1);

  // Field widths.
  localparam int XW     = 32;
  localparam int NW     = 18;
  localparam int DW     = 34;
  localparam int EW     = 16;
  localparam int CFG_IW = 3;
  localparam int CFG_DW = 32;

  // The crossing parameter is a Q0.16 fraction, one quotient bit per step.
  localparam int DIV_STEPS = 16;
  localparam int SW        = $clog2(DIV_STEPS);

  // Register reset values.
  localparam logic signed [NW-1:0] RST_NORMAL_X    = 18'sh00000;
  localparam logic signed [NW-1:0] RST_NORMAL_Y    = 18'sh10000;
  localparam logic signed [NW-1:0] RST_NORMAL_Z    = 18'sh00000;
  localparam logic signed [XW-1:0] RST_OFFSET      = 32'sh0;
  localparam logic                 RST_KEEP_INSIDE = 1'b1;
  localparam logic [EW-1:0]        RST_EPSILON     = 16'd66;

  // Distance saturation bounds, seen from the 38-bit pre-saturation sum.
  localparam logic signed [37:0] SUM_MAX = 38'sh01_FFFF_FFFF;
  localparam logic signed [37:0] SUM_MIN = 38'sh3E_0000_0000;
  localparam logic signed [DW-1:0] DIST_MAX = 34'sh1_FFFF_FFFF;
  localparam logic signed [DW-1:0] DIST_MIN = 34'sh2_0000_0000;

  typedef enum logic [CFG_IW-1:0] {
    CFG_NORMAL_X     = 3'd0,
    CFG_NORMAL_Y     = 3'd1,
    CFG_NORMAL_Z     = 3'd2,
    CFG_PLANE_OFFSET = 3'd3,
    CFG_KEEP_INSIDE  = 3'd4,
    CFG_EPSILON      = 3'd5
  } cfg_idx_t;

  typedef enum logic [1:0] {
    AX_X = 2'd0,
    AX_Y = 2'd1,
    AX_Z = 2'd2
  } axis_t;

  typedef struct packed {
    logic signed [XW-1:0] pos_x;
    logic signed [XW-1:0] pos_y;
    logic signed [XW-1:0] pos_z;
    logic                 vertex_last;
  } vtx_in_t;

  typedef struct packed {
    logic signed [XW-1:0] out_x;
    logic signed [XW-1:0] out_y;
    logic signed [XW-1:0] out_z;
    logic                 out_valid;
    logic                 out_last;
  } vtx_out_t;

  typedef struct packed {
    logic [XW-1:0] x;
    logic [XW-1:0] y;
    logic [XW-1:0] z;
  } vec3_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic          load_in;
    logic          dist_mul;
    logic          dist_acc;
    logic          dist_first;
    logic          dist_fin;
    logic          close;
    logic          push_a;
    logic          div_init;
    logic          div_step;
    logic          itp_mul;
    logic          itp_add;
    logic          push_i;
    logic          advance;
    logic [AW-1:0] addr;
    logic          ld0;
    logic          ldj;
    logic          wrap;
    logic          sq_mul;
    logic          sq_acc;
    logic          sq_first;
    logic          keep_wr;
    logic          emit_chk;
    logic          emit_inv;
    logic          clear;
    axis_t         mul_ax;
    axis_t         acc_ax;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic          room;
    logic          first;
    logic          enough;
    logic          last;
    logic          keep_a;
    logic          crossing;
    logic          cnt_ok;
    logic [CW-1:0] clip_n;
  } stat_t;

  function automatic logic [XW-1:0] pick(vec3_t v, axis_t a);
    case (a)
      AX_X:    pick = v.x;
      AX_Y:    pick = v.y;
      AX_Z:    pick = v.z;
      default: pick = v.x;
    endcase
  endfunction

endpackage

`default_nettype wire

// ===== hdl/ppc_ram.sv =====
// Generic simple dual-port RAM with registered read data.
`default_nettype none

module ppc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hdl/ppc_ctrl.sv =====
// Sequencing state machine of the polygon plane clipper.
`default_nettype none

module ppc_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  ppc_pkg::stat_t stat,
  output logic           busy,
  output ppc_pkg::cmd_t  cmd
);

  typedef enum logic [19:0] {
    S_IDLE  = 20'h00001,
    S_MUL   = 20'h00002,
    S_DFIN  = 20'h00004,
    S_EDGE  = 20'h00008,
    S_DIV   = 20'h00010,
    S_ITP   = 20'h00020,
    S_PUSHI = 20'h00040,
    S_ADV   = 20'h00080,
    S_TAIL  = 20'h00100,
    S_RD0   = 20'h00200,
    S_LD0   = 20'h00400,
    S_RDJ   = 20'h00800,
    S_LDJ   = 20'h01000,
    S_SQ    = 20'h02000,
    S_KEEP  = 20'h04000,
    S_ECHK  = 20'h08000,
    S_ERD   = 20'h10000,
    S_EOUT  = 20'h20000,
    S_INV   = 20'h40000,
    S_DONE  = 20'h80000
  } state_t;

  state_t                   state, state_next;
  logic [ppc_pkg::SW-1:0]   step, step_next;
  logic [ppc_pkg::AW-1:0]   idx, idx_next;
  logic                     close, close_next;
  logic [ppc_pkg::CW-1:0]   idx_inc;
  logic                     idx_last;
  logic                     step_lt;
  logic                     step_end;

  assign busy = (state != S_IDLE);

  always_comb begin
    idx_inc  = ppc_pkg::CW'(idx) + ppc_pkg::CW'(1);
    idx_last = (idx_inc == stat.clip_n);
    step_lt  = (step < ppc_pkg::SW'(ppc_pkg::NAXES));
    step_end = (step == ppc_pkg::SW'(ppc_pkg::NAXES));

    cmd        = '0;
    cmd.addr   = idx;
    cmd.close  = close;
    cmd.mul_ax = ppc_pkg::axis_t'(step[1:0]);
    cmd.acc_ax = ppc_pkg::axis_t'(step[1:0] - 2'd1);

    state_next = state;
    step_next  = step;
    idx_next   = idx;
    close_next = close;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load_in = 1'b1;
          step_next   = '0;
          close_next  = 1'b0;
          state_next  = stat.room ? S_MUL : S_TAIL;
        end
      end
      S_MUL: begin
        cmd.dist_mul   = step_lt;
        cmd.dist_acc   = (step != '0);
        cmd.dist_first = (step == ppc_pkg::SW'(1));
        if (step_end) begin
          state_next = S_DFIN;
        end else begin
          step_next = step + ppc_pkg::SW'(1);
        end
      end
      S_DFIN: begin
        cmd.dist_fin = 1'b1;
        state_next   = stat.first ? S_ADV : S_EDGE;
      end
      S_EDGE: begin
        cmd.push_a   = stat.keep_a;
        cmd.div_init = 1'b1;
        step_next    = '0;
        if (stat.crossing) begin
          state_next = S_DIV;
        end else begin
          state_next = close ? S_RD0 : S_ADV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (step == ppc_pkg::SW'(ppc_pkg::DIV_STEPS - 1)) begin
          step_next  = '0;
          state_next = S_ITP;
        end else begin
          step_next = step + ppc_pkg::SW'(1);
        end
      end
      S_ITP: begin
        cmd.itp_mul = step_lt;
        cmd.itp_add = (step != '0);
        if (step_end) begin
          state_next = S_PUSHI;
        end else begin
          step_next = step + ppc_pkg::SW'(1);
        end
      end
      S_PUSHI: begin
        cmd.push_i = 1'b1;
        state_next = close ? S_RD0 : S_ADV;
      end
      S_ADV: begin
        cmd.advance = 1'b1;
        state_next  = S_TAIL;
      end
      S_TAIL: begin
        if (!stat.last) begin
          state_next = S_IDLE;
        end else if (stat.enough) begin
          close_next = 1'b1;
          state_next = S_EDGE;
        end else begin
          state_next = S_INV;
        end
      end
      S_RD0: begin
        cmd.addr = '0;
        if (stat.clip_n == '0) begin
          state_next = S_INV;
        end else begin
          state_next = S_LD0;
        end
      end
      S_LD0: begin
        cmd.ld0    = 1'b1;
        idx_next   = '0;
        state_next = S_RDJ;
      end
      S_RDJ: begin
        cmd.addr   = idx_inc[ppc_pkg::AW-1:0];
        state_next = S_LDJ;
      end
      S_LDJ: begin
        cmd.ldj    = 1'b1;
        cmd.wrap   = idx_last;
        step_next  = '0;
        state_next = S_SQ;
      end
      S_SQ: begin
        cmd.sq_mul   = step_lt;
        cmd.sq_acc   = (step != '0);
        cmd.sq_first = (step == ppc_pkg::SW'(1));
        if (step_end) begin
          state_next = S_KEEP;
        end else begin
          step_next = step + ppc_pkg::SW'(1);
        end
      end
      S_KEEP: begin
        cmd.keep_wr = 1'b1;
        if (idx_last) begin
          state_next = S_ECHK;
        end else begin
          idx_next   = idx + ppc_pkg::AW'(1);
          state_next = S_RDJ;
        end
      end
      S_ECHK: begin
        if (stat.cnt_ok) begin
          idx_next   = '0;
          state_next = S_ERD;
        end else begin
          state_next = S_INV;
        end
      end
      S_ERD: begin
        state_next = S_EOUT;
      end
      S_EOUT: begin
        cmd.emit_chk = 1'b1;
        if (idx_last) begin
          state_next = S_DONE;
        end else begin
          idx_next   = idx + ppc_pkg::AW'(1);
          state_next = S_ERD;
        end
      end
      S_INV: begin
        cmd.emit_inv = 1'b1;
        state_next   = S_DONE;
      end
      S_DONE: begin
        cmd.clear  = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
      idx   <= '0;
      close <= 1'b0;
    end else begin
      state <= state_next;
      step  <= step_next;
      idx   <= idx_next;
      close <= close_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/ppc_dp.sv =====
// Datapath of the polygon plane clipper: registers, arithmetic and result buffer.
`default_nettype none

module ppc_dp (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [ppc_pkg::CFG_IW-1:0]   cfg_index,
  input  logic [ppc_pkg::CFG_DW-1:0]   cfg_data,
  input  ppc_pkg::vtx_in_t             vertex,
  input  ppc_pkg::cmd_t                cmd,
  output ppc_pkg::stat_t               stat,
  output logic                         result_valid,
  output ppc_pkg::vtx_out_t            result
);

  // Configuration registers.
  logic signed [ppc_pkg::NW-1:0] normal_x, normal_y, normal_z;
  logic signed [ppc_pkg::XW-1:0] plane_offset;
  logic                          keep_inside;
  logic [ppc_pkg::EW-1:0]        epsilon;
  logic [2*ppc_pkg::EW-1:0]      e2;

  // Polygon state.
  ppc_pkg::vec3_t                cur, prev, first, ipt;
  logic                          last_flag;
  logic signed [ppc_pkg::DW-1:0] cur_dist, prev_dist, first_dist;
  logic [ppc_pkg::ICW-1:0]       input_count;
  logic [ppc_pkg::CW-1:0]        clip_count;

  // Arithmetic registers.
  logic signed [49:0]            mprod;
  logic signed [51:0]            acc;
  logic [35:0]                   rem, den;
  logic [ppc_pkg::DIV_STEPS-1:0] q;
  logic signed [49:0]            iprod;
  ppc_pkg::vec3_t                e0, ea, eb;
  logic [63:0]                   sqprod, sum;
  logic                          sqsat;
  logic [ppc_pkg::OUT_DEPTH-1:0] keep;
  logic [ppc_pkg::CW-1:0]        cnt, kout;

  // Buffer port.
  logic                          ram_we;
  ppc_pkg::vec3_t                ram_wdata, ram_rdata;

  // Combinational terms.
  logic signed [ppc_pkg::NW-1:0] n_sel;
  logic [ppc_pkg::XW-1:0]        p_sel;
  logic signed [35:0]            sh;
  logic signed [37:0]            s_sum, s_adj;
  logic signed [ppc_pkg::DW-1:0] dist_sat, db;
  logic signed [35:0]            da36, db36, ev, dpe, dme, bpe, bme, dd;
  logic [ppc_pkg::DW-1:0]        abs_da;
  logic [35:0]                   abs_dd, r2;
  logic                          a_pos, a_neg, b_pos, b_neg;
  ppc_pkg::vec3_t                bvec;
  logic [ppc_pkg::XW-1:0]        av, bv, ia;
  logic signed [32:0]            idiff, sdiff;
  logic [ppc_pkg::XW-1:0]        ires, sa, sb;
  logic [32:0]                   sabs;
  logic [63:0]                   sbase;
  logic [64:0]                   ssum;
  logic                          kbit;

  always_comb begin
    case (cmd.mul_ax)
      ppc_pkg::AX_X: n_sel = normal_x;
      ppc_pkg::AX_Y: n_sel = normal_y;
      ppc_pkg::AX_Z: n_sel = normal_z;
      default:       n_sel = normal_x;
    endcase
    p_sel = ppc_pkg::pick(cur, cmd.mul_ax);

    // Floor shift, offset, side selection and saturation.
    sh    = acc[51:16];
    s_sum = {{2{sh[35]}}, sh} + {{6{plane_offset[31]}}, plane_offset};
    s_adj = keep_inside ? (38'sd0 - s_sum) : s_sum;
    if (s_adj > ppc_pkg::SUM_MAX) begin
      dist_sat = ppc_pkg::DIST_MAX;
    end else if (s_adj < ppc_pkg::SUM_MIN) begin
      dist_sat = ppc_pkg::DIST_MIN;
    end else begin
      dist_sat = s_adj[ppc_pkg::DW-1:0];
    end

    // Edge classification against the tolerance band.
    db   = cmd.close ? first_dist : cur_dist;
    bvec = cmd.close ? first : cur;
    da36 = {{2{prev_dist[33]}}, prev_dist};
    db36 = {{2{db[33]}}, db};
    ev   = {20'd0, epsilon};
    dpe  = da36 + ev;
    dme  = da36 - ev;
    bpe  = db36 + ev;
    bme  = db36 - ev;
    a_pos = !dme[35] && (dme != '0);
    a_neg = dpe[35];
    b_pos = !bme[35] && (bme != '0);
    b_neg = bpe[35];
    abs_da = prev_dist[33] ? ppc_pkg::DW'(-prev_dist) : ppc_pkg::DW'(prev_dist);
    dd     = da36 - db36;
    abs_dd = dd[35] ? 36'(-dd) : 36'(dd);
    r2     = {rem[34:0], 1'b0};

    // Interpolation operands.
    av    = ppc_pkg::pick(prev, cmd.mul_ax);
    bv    = ppc_pkg::pick(bvec, cmd.mul_ax);
    idiff = $signed({bv[31], bv}) - $signed({av[31], av});
    ia    = ppc_pkg::pick(prev, cmd.acc_ax);
    ires  = ia + iprod[47:16];

    // Squared gap operands.
    sa    = ppc_pkg::pick(ea, cmd.mul_ax);
    sb    = ppc_pkg::pick(eb, cmd.mul_ax);
    sdiff = $signed({sa[31], sa}) - $signed({sb[31], sb});
    sabs  = sdiff[32] ? 33'(-sdiff) : 33'(sdiff);
    sbase = cmd.sq_first ? 64'd0 : sum;
    ssum  = {1'b0, sbase} + {1'b0, sqprod};
    kbit  = keep[cmd.addr];

    ram_we    = (cmd.push_a || cmd.push_i) &&
                (clip_count < ppc_pkg::CW'(ppc_pkg::OUT_DEPTH));
    ram_wdata = cmd.push_i ? ipt : prev;

    stat.room     = (input_count < ppc_pkg::ICW'(ppc_pkg::MAX_IN_VERTS));
    stat.first    = (input_count == '0);
    stat.enough   = (input_count >= ppc_pkg::ICW'(ppc_pkg::MIN_VERTS));
    stat.last     = last_flag;
    stat.keep_a   = !dpe[35];
    stat.crossing = (a_pos && b_neg) || (a_neg && b_pos);
    stat.cnt_ok   = (cnt >= ppc_pkg::CW'(ppc_pkg::MIN_VERTS));
    stat.clip_n   = clip_count;
  end

  ppc_ram #(
    .WIDTH($bits(ppc_pkg::vec3_t)),
    .DEPTH(ppc_pkg::OUT_DEPTH)
  ) u_buf (
    .clk  (clk),
    .we   (ram_we),
    .waddr(clip_count[ppc_pkg::AW-1:0]),
    .wdata(ram_wdata),
    .raddr(cmd.addr),
    .rdata(ram_rdata)
  );

  // Control state and configuration.
  always_ff @(posedge clk) begin
    if (rst) begin
      normal_x     <= ppc_pkg::RST_NORMAL_X;
      normal_y     <= ppc_pkg::RST_NORMAL_Y;
      normal_z     <= ppc_pkg::RST_NORMAL_Z;
      plane_offset <= ppc_pkg::RST_OFFSET;
      keep_inside  <= ppc_pkg::RST_KEEP_INSIDE;
      epsilon      <= ppc_pkg::RST_EPSILON;
      input_count  <= '0;
      clip_count   <= '0;
      cnt          <= '0;
      kout         <= '0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (ppc_pkg::cfg_idx_t'(cfg_index))
          ppc_pkg::CFG_NORMAL_X:     normal_x     <= cfg_data[ppc_pkg::NW-1:0];
          ppc_pkg::CFG_NORMAL_Y:     normal_y     <= cfg_data[ppc_pkg::NW-1:0];
          ppc_pkg::CFG_NORMAL_Z:     normal_z     <= cfg_data[ppc_pkg::NW-1:0];
          ppc_pkg::CFG_PLANE_OFFSET: plane_offset <= cfg_data[ppc_pkg::XW-1:0];
          ppc_pkg::CFG_KEEP_INSIDE:  keep_inside  <= cfg_data[0];
          ppc_pkg::CFG_EPSILON:      epsilon      <= cfg_data[ppc_pkg::EW-1:0];
          default: ;
        endcase
      end
      if (cmd.advance) begin
        input_count <= input_count + ppc_pkg::ICW'(1);
      end
      if (ram_we) begin
        clip_count <= clip_count + ppc_pkg::CW'(1);
      end
      if (cmd.keep_wr && (sum > {32'd0, e2})) begin
        cnt <= cnt + ppc_pkg::CW'(1);
      end
      result_valid <= cmd.emit_inv || (cmd.emit_chk && kbit);
      if (cmd.emit_chk && kbit) begin
        kout <= kout + ppc_pkg::CW'(1);
      end
      if (cmd.clear) begin
        input_count <= '0;
        clip_count  <= '0;
        cnt         <= '0;
        kout        <= '0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    e2 <= epsilon * epsilon;
    if (cmd.load_in) begin
      cur.x     <= vertex.pos_x;
      cur.y     <= vertex.pos_y;
      cur.z     <= vertex.pos_z;
      last_flag <= vertex.vertex_last;
    end
    if (cmd.dist_mul) begin
      mprod <= n_sel * $signed(p_sel);
    end
    if (cmd.dist_acc) begin
      acc <= cmd.dist_first ? {{2{mprod[49]}}, mprod} : acc + {{2{mprod[49]}}, mprod};
    end
    if (cmd.dist_fin) begin
      cur_dist <= dist_sat;
    end
    if (cmd.div_init) begin
      rem <= 36'(abs_da);
      den <= abs_dd;
    end
    if (cmd.div_step) begin
      if (r2 >= den) begin
        rem <= r2 - den;
        q   <= {q[ppc_pkg::DIV_STEPS-2:0], 1'b1};
      end else begin
        rem <= r2;
        q   <= {q[ppc_pkg::DIV_STEPS-2:0], 1'b0};
      end
    end
    if (cmd.itp_mul) begin
      iprod <= idiff * $signed({1'b0, q});
    end
    if (cmd.itp_add) begin
      case (cmd.acc_ax)
        ppc_pkg::AX_X: ipt.x <= ires;
        ppc_pkg::AX_Y: ipt.y <= ires;
        ppc_pkg::AX_Z: ipt.z <= ires;
        default: ;
      endcase
    end
    if (cmd.advance) begin
      prev      <= cur;
      prev_dist <= cur_dist;
      if (input_count == '0) begin
        first      <= cur;
        first_dist <= cur_dist;
      end
    end
    if (cmd.ld0) begin
      e0 <= ram_rdata;
      ea <= ram_rdata;
    end
    if (cmd.ldj) begin
      eb <= cmd.wrap ? e0 : ram_rdata;
    end
    if (cmd.sq_mul) begin
      sqprod <= sabs[31:0] * sabs[31:0];
      sqsat  <= sabs[32];
    end
    if (cmd.sq_acc) begin
      sum <= (ssum[64] || sqsat) ? '1 : ssum[63:0];
    end
    if (cmd.keep_wr) begin
      keep[cmd.addr] <= (sum > {32'd0, e2});
      ea             <= eb;
    end
    if (cmd.emit_chk && kbit) begin
      result.out_x     <= ram_rdata.x;
      result.out_y     <= ram_rdata.y;
      result.out_z     <= ram_rdata.z;
      result.out_valid <= 1'b1;
      result.out_last  <= ((kout + ppc_pkg::CW'(1)) == cnt);
    end else if (cmd.emit_inv) begin
      result.out_x     <= '0;
      result.out_y     <= '0;
      result.out_z     <= '0;
      result.out_valid <= 1'b0;
      result.out_last  <= 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/polygon_plane_clipper_top.sv =====
// Top level of the polygon plane clipper: controller, datapath and checks.
// A vertex transaction computes the plane distance; later vertices also classify the edge and,
// when it crosses the plane, run the bit-serial divider for the crossing fraction and
// interpolate; a vertex beyond the input limit skips straight to the end-of-polygon check.
// The last vertex adds the closing edge, primes the duplicate scan by reading and loading the
// first buffered point, scans each point by read, load, squared gap and keep-flag write, and
// reads out the kept points through the single buffer read port; results are strobes.
// Reset restores the register defaults and empties the polygon; buffer contents stay as-is.
`default_nettype none

module polygon_plane_clipper_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  ppc_pkg::vtx_in_t           vertex,
  output logic                       result_valid,
  output ppc_pkg::vtx_out_t          result,
  input  logic                       cfg_we,
  input  logic [ppc_pkg::CFG_IW-1:0] cfg_index,
  input  logic [ppc_pkg::CFG_DW-1:0] cfg_data
);

  // The controller walks each transaction through distance, edge, divide,
  // interpolate, and on the closing vertex through scan and readout.
  ppc_pkg::cmd_t  cmd;
  ppc_pkg::stat_t stat;

  ppc_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .stat (stat),
    .busy (busy),
    .cmd  (cmd)
  );

  // The datapath holds the configuration, polygon state, result buffer and
  // the single registered output stage.
  ppc_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .vertex      (vertex),
    .cmd         (cmd),
    .stat        (stat),
    .result_valid(result_valid),
    .result      (result)
  );

  // Results only appear while a transaction is still being worked off.
  a_result_in_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> busy)
    else $error("result strobe outside a busy period");

  // The final result of a polygon is followed by a gap.
  a_last_gap: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.out_last) |=> !result_valid)
    else $error("result directly after the final result");

  // An invalid result always closes the polygon.
  a_invalid_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.out_valid) |-> result.out_last)
    else $error("invalid result not marked last");

  // An accepted vertex always starts work.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted vertex did not raise busy");

endmodule

`default_nettype wire
